### rtl/core/jts_pkg.sv
// Package for the JSON token scanner: scan states, token kinds and character codes.
// Depends on nothing; imported by json_token_scanner.
package jts_pkg;

    // Width of the number_value field on the result port.
    localparam int VALUE_WIDTH = 32;
    // Widest accumulator that the scanner supports.
    localparam int ACCUM_MAX_WIDTH = 64;

    // Scan states, one-hot.
    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_NULL1  = 12'b0000_0000_0010,
        ST_NULL2  = 12'b0000_0000_0100,
        ST_NULL3  = 12'b0000_0000_1000,
        ST_FALSE1 = 12'b0000_0001_0000,
        ST_FALSE2 = 12'b0000_0010_0000,
        ST_FALSE3 = 12'b0000_0100_0000,
        ST_FALSE4 = 12'b0000_1000_0000,
        ST_TRUE1  = 12'b0001_0000_0000,
        ST_TRUE2  = 12'b0010_0000_0000,
        ST_TRUE3  = 12'b0100_0000_0000,
        ST_NUM    = 12'b1000_0000_0000
    } scan_state_t;

    // Token kinds on the result port.
    typedef enum logic [3:0] {
        TOK_ARR_START = 4'd0,
        TOK_ARR_END   = 4'd1,
        TOK_SEP       = 4'd2,
        TOK_OBJ_START = 4'd3,
        TOK_OBJ_END   = 4'd4,
        TOK_KEY_SEP   = 4'd5,
        TOK_NULL      = 4'd6,
        TOK_FALSE     = 4'd7,
        TOK_TRUE      = 4'd8,
        TOK_NUMBER    = 4'd9
    } token_kind_t;

    // Character codes.
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_L         = 8'h6C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_S         = 8'h73;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

endpackage

### rtl/core/json_token_scanner.sv
// Byte-serial JSON token scanner: structural marks, null/false/true literals and
// saturating unsigned decimal integers. Depends on jts_pkg.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  byte     | in        | byte_valid / byte_stall   | in_byte[7:0]
//  token    | out       | token_valid / token_stall | token_kind[3:0], number_value[31:0]
//
// One byte is taken every cycle while byte_stall is low.
// The bytes pass an input register, then one pass of state logic with a shift-add
// multiply by ten, then the token register.
// Reset returns the scanner to idle with a zero accumulator and empties both registers.
// A stalled token holds the input register only when the waiting byte would emit a token.
module json_token_scanner #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  logic [7:0]                          in_byte,
    output logic                                token_valid,
    input  logic                                token_stall,
    output logic [3:0]                          token_kind,
    output logic [jts_pkg::VALUE_WIDTH-1:0]     number_value
);
    import jts_pkg::*;

    localparam int SUM_WIDTH = NUMBER_WIDTH + 4;

    logic                       byte_valid_reg;
    logic [7:0]                 byte_reg;
    scan_state_t                scan_state_reg;
    scan_state_t                scan_state_next;
    logic [NUMBER_WIDTH-1:0]    accum_reg;
    logic [NUMBER_WIDTH-1:0]    accum_next;
    logic                       token_valid_reg;
    token_kind_t                token_kind_reg;
    token_kind_t                token_kind_next;
    logic [VALUE_WIDTH-1:0]     number_value_reg;
    logic [VALUE_WIDTH-1:0]     number_value_next;
    logic                       emit;
    logic                       advance;
    logic                       is_digit;
    logic                       is_space;
    logic [3:0]                 digit;
    logic [SUM_WIDTH-1:0]       accum_ext;
    logic [SUM_WIDTH-1:0]       accum_sum;
    logic [NUMBER_WIDTH-1:0]    accum_scaled;
    logic [ACCUM_MAX_WIDTH-1:0] accum_wide;

    // Character classes of the byte in the input register.
    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_space = (byte_reg == CH_SPACE) || (byte_reg == CH_TAB)
                      || (byte_reg == CH_LF) || (byte_reg == CH_CR);
    assign digit    = 4'(byte_reg - CH_ZERO);

    // Accumulator times ten plus the digit; any carry above the width saturates.
    assign accum_ext    = SUM_WIDTH'(accum_reg);
    assign accum_sum    = (accum_ext << 3) + (accum_ext << 1) + SUM_WIDTH'(digit);
    assign accum_scaled = (|accum_sum[SUM_WIDTH-1:NUMBER_WIDTH])
                          ? {NUMBER_WIDTH{1'b1}} : accum_sum[NUMBER_WIDTH-1:0];

    // The result field carries the low bits of the accumulator.
    assign accum_wide = ACCUM_MAX_WIDTH'(accum_reg);

    // Next state, accumulator and token for the byte in the input register.
    always_comb
    begin
        scan_state_next   = scan_state_reg;
        accum_next        = accum_reg;
        emit              = 1'b0;
        token_kind_next   = TOK_NUMBER;
        number_value_next = '0;
        case (scan_state_reg)
            ST_NULL1:  if (byte_reg == CH_U) scan_state_next = ST_NULL2;
            ST_NULL2:  if (byte_reg == CH_L) scan_state_next = ST_NULL3;
            ST_NULL3:
            begin
                if (byte_reg == CH_L)
                begin
                    scan_state_next = ST_IDLE;
                    emit            = 1'b1;
                    token_kind_next = TOK_NULL;
                end
            end
            ST_FALSE1: if (byte_reg == CH_A) scan_state_next = ST_FALSE2;
            ST_FALSE2: if (byte_reg == CH_L) scan_state_next = ST_FALSE3;
            ST_FALSE3: if (byte_reg == CH_S) scan_state_next = ST_FALSE4;
            ST_FALSE4:
            begin
                if (byte_reg == CH_E)
                begin
                    scan_state_next = ST_IDLE;
                    emit            = 1'b1;
                    token_kind_next = TOK_FALSE;
                end
            end
            ST_TRUE1:  if (byte_reg == CH_R) scan_state_next = ST_TRUE2;
            ST_TRUE2:  if (byte_reg == CH_U) scan_state_next = ST_TRUE3;
            ST_TRUE3:
            begin
                if (byte_reg == CH_E)
                begin
                    scan_state_next = ST_IDLE;
                    emit            = 1'b1;
                    token_kind_next = TOK_TRUE;
                end
            end
            ST_NUM:
            begin
                if (is_digit)
                begin
                    accum_next = accum_scaled;
                end
                else if (is_space)
                begin
                    scan_state_next   = ST_IDLE;
                    emit              = 1'b1;
                    token_kind_next   = TOK_NUMBER;
                    number_value_next = accum_wide[VALUE_WIDTH-1:0];
                end
            end
            default:
            begin
                // Idle, and any code that is not a state, starts a new token.
                scan_state_next = ST_IDLE;
                case (byte_reg)
                    CH_N:        scan_state_next = ST_NULL1;
                    CH_F:        scan_state_next = ST_FALSE1;
                    CH_T:        scan_state_next = ST_TRUE1;
                    CH_LBRACKET: begin emit = 1'b1; token_kind_next = TOK_ARR_START; end
                    CH_RBRACKET: begin emit = 1'b1; token_kind_next = TOK_ARR_END;   end
                    CH_COMMA:    begin emit = 1'b1; token_kind_next = TOK_SEP;       end
                    CH_LBRACE:   begin emit = 1'b1; token_kind_next = TOK_OBJ_START; end
                    CH_RBRACE:   begin emit = 1'b1; token_kind_next = TOK_OBJ_END;   end
                    CH_COLON:    begin emit = 1'b1; token_kind_next = TOK_KEY_SEP;   end
                    default:
                    begin
                        if (is_digit)
                        begin
                            scan_state_next = ST_NUM;
                            accum_next      = NUMBER_WIDTH'(digit);
                        end
                    end
                endcase
            end
        endcase
    end

    // The held byte moves on unless it would emit into a full, stalled token register.
    assign advance    = byte_valid_reg && (!emit || !token_valid_reg || !token_stall);
    assign byte_stall = byte_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            byte_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    // Scanner state and accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state_reg <= ST_IDLE;
            accum_reg      <= '0;
        end
        else if (advance)
        begin
            scan_state_reg <= scan_state_next;
            accum_reg      <= accum_next;
        end
    end

    // Token register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            token_valid_reg <= 1'b1;
        end
        else if (!token_stall)
        begin
            token_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            token_kind_reg   <= token_kind_next;
            number_value_reg <= number_value_next;
        end
    end

    assign token_valid  = token_valid_reg;
    assign token_kind   = token_kind_reg;
    assign number_value = number_value_reg;

`ifndef SYNTHESIS
    // Only a number token carries a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid_reg && token_kind_reg != TOK_NUMBER) |-> number_value_reg == '0)
        else $error("non-number token with a nonzero value");

    // A digit inside a number never makes the accumulator smaller.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && scan_state_reg == ST_NUM && is_digit) |=> accum_reg >= $past(accum_reg))
        else $error("accumulator decreased on a digit");

    // Whitespace ends a number with a number token and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && scan_state_reg == ST_NUM && is_space)
        |=> token_valid_reg && token_kind_reg == TOK_NUMBER && scan_state_reg == ST_IDLE)
        else $error("number not emitted on whitespace");

    // The last letter of null emits the null token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && scan_state_reg == ST_NULL3 && byte_reg == CH_L)
        |=> token_valid_reg && token_kind_reg == TOK_NULL)
        else $error("null literal not emitted");
`endif

endmodule
